// ===== rtl/core/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// Types, constants and the digit-to-character map for the integer-to-ASCII
// converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    // quotient bits resolved per divide cycle
    localparam int STEP_BITS = 8;

    localparam logic [4:0] BASE_MIN = 5'd2;
    localparam logic [4:0] BASE_MAX = 5'd16;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;   // '0'
    localparam logic [6:0] CHAR_LOWER = 7'h61;   // 'a'
    localparam logic [6:0] CHAR_UPPER = 7'h41;   // 'A'
    localparam logic [3:0] DIGIT_TEN  = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_LOAD
    } state_t;

    function automatic logic [6:0] digit_to_ascii(input logic [3:0] digit,
                                                  input logic       upper);
        logic [6:0] ch;
        if (digit < DIGIT_TEN)
        begin
            ch = CHAR_ZERO + {3'd0, digit};
        end
        else if (upper)
        begin
            ch = CHAR_UPPER + {3'd0, digit - DIGIT_TEN};
        end
        else
        begin
            ch = CHAR_LOWER + {3'd0, digit - DIGIT_TEN};
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/radix_integer_to_ascii.sv =====
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// Converts an unsigned integer to ASCII digits in base 2 to 16.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the s_axis channel carries a value, a base and a case flag.
//   The block answers with one character per m_axis transfer, most
//   significant digit first, tlast on the final digit. Zero gives "0".
//   Bases below 2 act as 2, bases above 16 act as 16.
// Timing:
//   One request is converted at a time. Each digit is found by the shared
//   8-bit-per-cycle long divider, which writes the digit into the digit
//   memory least significant first. The digits are then read back in
//   reverse, each character by a memory read and then an output load.
// Reset and stall:
//   Reset returns the control to idle and drops any pending character.
//   A stalled receiver holds the output register; the read-back waits. The
//   next request is taken as soon as the last character sits in the output
//   register, even while it still waits for the receiver.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] value, [68:64] base, [69] upper
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] digit_char
    output logic        m_axis_tlast    // last
);

    localparam int STEP   = i2a_pkg::STEP_BITS;
    localparam int CHUNKS = (VALUE_WIDTH + STEP - 1) / STEP;
    localparam int W_PAD  = CHUNKS * STEP;
    localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int AW     = $clog2(VALUE_WIDTH);
    localparam int NW     = $clog2(VALUE_WIDTH + 1);

    i2a_pkg::state_t state_reg, state_next;

    logic [W_PAD-1:0] quot_reg, quot_next;
    logic [3:0]       rem_reg, rem_next;
    logic [CW-1:0]    chunk_reg, chunk_next;
    logic [4:0]       base_reg, base_next;
    logic             upper_reg, upper_next;
    logic [NW-1:0]    ndig_reg, ndig_next;

    logic             m_valid_reg, m_valid_next;
    logic [6:0]       m_char_reg, m_char_next;
    logic             m_last_reg, m_last_next;

    logic [3:0]       dig_mem [VALUE_WIDTH];
    logic [3:0]       rdata_reg;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    logic             s_fire;
    logic             out_free;
    logic             load_out;
    logic             last_chunk;
    logic             quot_zero;

    logic [STEP-1:0]  qbits;
    logic [3:0]       rem_step;
    logic [W_PAD-1:0] quot_shift;
    logic [4:0]       base_in;
    logic [4:0]       base_clamped;
    logic [W_PAD-1:0] value_in;

    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign load_out   = (state_reg == i2a_pkg::ST_LOAD) && out_free;
    assign last_chunk = (chunk_reg == CW'(CHUNKS - 1));
    assign quot_zero  = (quot_shift == '0);
    assign wr_addr    = ndig_reg[AW-1:0];
    assign rd_addr    = AW'(ndig_reg - NW'(1));

    assign base_in      = s_axis_tdata[68:64];
    assign base_clamped = (base_in < i2a_pkg::BASE_MIN) ? i2a_pkg::BASE_MIN :
                          (base_in > i2a_pkg::BASE_MAX) ? i2a_pkg::BASE_MAX : base_in;
    assign value_in     = W_PAD'(s_axis_tdata[VALUE_WIDTH-1:0]);

    // long division by the base, STEP quotient bits per cycle
    always_comb
    begin
        logic [4:0] r;
        r     = {1'b0, rem_reg};
        qbits = '0;
        for (int i = 0; i < STEP; i++)
        begin
            r = {r[3:0], quot_reg[W_PAD-1-i]};
            if (r >= base_reg)
            begin
                r = r - base_reg;
                qbits[STEP-1-i] = 1'b1;
            end
        end
        rem_step   = r[3:0];
        quot_shift = (quot_reg << STEP) | W_PAD'(qbits);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = i2a_pkg::ST_DIV;
                end
            end
            i2a_pkg::ST_DIV:
            begin
                if (last_chunk && quot_zero)
                begin
                    state_next = i2a_pkg::ST_READ;
                end
            end
            i2a_pkg::ST_READ:
            begin
                state_next = i2a_pkg::ST_LOAD;
            end
            i2a_pkg::ST_LOAD:
            begin
                if (load_out)
                begin
                    state_next = (ndig_reg == NW'(1)) ? i2a_pkg::ST_IDLE : i2a_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        s_axis_tready = (state_reg == i2a_pkg::ST_IDLE);
        mem_we        = (state_reg == i2a_pkg::ST_DIV) && last_chunk;
        mem_re        = (state_reg == i2a_pkg::ST_READ);

        quot_next  = quot_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        base_next  = base_reg;
        upper_next = upper_reg;
        ndig_next  = ndig_reg;

        if (s_fire)
        begin
            quot_next  = value_in;
            rem_next   = '0;
            chunk_next = '0;
            base_next  = base_clamped;
            upper_next = s_axis_tdata[69];
            ndig_next  = '0;
        end
        else if (state_reg == i2a_pkg::ST_DIV)
        begin
            quot_next  = quot_shift;
            rem_next   = rem_step;
            chunk_next = last_chunk ? '0 : chunk_reg + CW'(1);
            if (last_chunk)
            begin
                // digit is complete: restart remainder for the next one
                rem_next  = '0;
                ndig_next = ndig_reg + NW'(1);
            end
        end
        else if (load_out)
        begin
            ndig_next = ndig_reg - NW'(1);
        end

        m_valid_next = m_valid_reg && !m_axis_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
            m_char_next  = i2a_pkg::digit_to_ascii(rdata_reg, upper_reg);
            m_last_next  = (ndig_reg == NW'(1));
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_char_reg};
    assign m_axis_tlast  = m_last_reg;

    // digit memory, least significant digit at address 0
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dig_mem[wr_addr] <= rem_step;
        end
        if (mem_re)
        begin
            rdata_reg <= dig_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= i2a_pkg::ST_IDLE;
            chunk_reg   <= '0;
            ndig_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chunk_reg   <= chunk_next;
            ndig_reg    <= ndig_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        base_reg   <= base_next;
        upper_reg  <= upper_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

endmodule

// ===== rtl/core/i2a_checker.sv =====
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks for the integer-to-ASCII converter.
// ----------------------------------------------------------------------------
module i2a_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // one request at a time: no second accept right behind the first
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted back to back");

    // more digits pending: input stays blocked
    a_block_mid_string: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input ready before last digit");

    // every character is a digit of base 16 or less
    a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
             (m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h66) ||
             (m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h46)))
        else $error("character out of digit range");

    // stalled output holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output changed while stalled");

endmodule

bind radix_integer_to_ascii i2a_checker u_i2a_checker (.*);
